// File: rtl/core/cdrb_pkg.sv
// Shared types, register offsets and masks of the cart DMA register block.
package cdrb_pkg;

   // Access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register window, in words
   localparam logic [3:0] OFF_DRAM_ADDR     = 4'd0;
   localparam logic [3:0] OFF_CART_ADDR     = 4'd1;
   localparam logic [3:0] OFF_READ_LEN      = 4'd2;
   localparam logic [3:0] OFF_WRITE_LEN     = 4'd3;
   localparam logic [3:0] OFF_STATUS        = 4'd4;
   localparam logic [3:0] OFF_SCRATCH_FIRST = 4'd5;
   localparam logic [3:0] OFF_SCRATCH_LAST  = 4'd12;

   localparam int SCRATCH_DEPTH = 8;
   localparam int SCRATCH_IDX_W = $clog2(SCRATCH_DEPTH);

   // Field widths and masks
   localparam int DRAM_ADDR_W = 23;
   localparam int LEN_W       = 25;
   localparam int LEN_FIELD_W = 24;
   localparam logic [DRAM_ADDR_W-1:0] DRAM_ALIGN_MASK = 23'h7FFFFE;
   localparam logic [31:0]            CART_ALIGN_MASK = 32'hFFFFFFFE;

   // Status register bits
   localparam int STATUS_IRQ_CLEAR_BIT = 1;
   localparam int STATUS_IRQ_READ_BIT  = 3;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  word_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0]            read_data;
      logic                   dma_start;
      logic                   dma_to_cart;
      logic [DRAM_ADDR_W-1:0] dma_dram_address;
      logic [31:0]            dma_cart_address;
      logic [LEN_W-1:0]       dma_length;
      logic                   irq_pending;
      logic                   bad_access;
   } rsp_type;

endpackage

// File: rtl/core/cdrb_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
interface cdrb_req_if import cdrb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cdrb_rsp_if import cdrb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cdrb_in_stage.sv
// Input register: holds one accepted bus access until the core takes it.
module cdrb_in_stage import cdrb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdrb_req_if.sink  req_bus,
   input  logic      take,
   output logic      held_valid,
   output req_type   held_item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   // Accept a new transfer when empty or when the held one moves on
   assign req_bus.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_bus.valid && req_bus.ready) begin
         valid_in = 1'b1;
         item_in  = req_bus.data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: rtl/core/cdrb_core.sv
// Register file and DMA launch logic: updates state and forms one result per access.
module cdrb_core import cdrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [31:0]      dram_ptr_ff, dram_ptr_in;
   logic [31:0]      cart_ptr_ff, cart_ptr_in;
   logic [LEN_W-1:0] read_len_ff, read_len_in;
   logic [LEN_W-1:0] write_len_ff, write_len_in;
   logic [7:0]       scratch_ff [SCRATCH_DEPTH];
   logic [7:0]       scratch_in [SCRATCH_DEPTH];
   logic             irq_ff, irq_in;

   logic [LEN_W-1:0]         req_len;
   logic [DRAM_ADDR_W-1:0]   dram_start;
   logic [31:0]              cart_start;
   logic [2:0]               skew;
   logic [LEN_W-1:0]         dma_len;
   logic [SCRATCH_IDX_W-1:0] scratch_idx;
   logic                     is_scratch;
   logic [3:0]               scratch_off;

   // Launch parameters, computed for every access and used on length writes
   always_comb begin
      req_len    = {1'b0, item.write_data[LEN_FIELD_W-1:0]} + LEN_W'(1);
      dram_start = dram_ptr_ff[DRAM_ADDR_W-1:0] & DRAM_ALIGN_MASK;
      cart_start = cart_ptr_ff & CART_ALIGN_MASK;
      skew       = dram_start[2:0];
      // Clamp at zero where the subtraction would wrap
      if (req_len > LEN_W'(skew)) begin
         dma_len = req_len - LEN_W'(skew);
      end else begin
         dma_len = '0;
      end
   end

   assign is_scratch  = (item.word_offset inside {[OFF_SCRATCH_FIRST:OFF_SCRATCH_LAST]});
   assign scratch_off = item.word_offset - OFF_SCRATCH_FIRST;
   assign scratch_idx = scratch_off[SCRATCH_IDX_W-1:0];

   // Decode the access: next state and result
   always_comb begin
      dram_ptr_in  = dram_ptr_ff;
      cart_ptr_in  = cart_ptr_ff;
      read_len_in  = read_len_ff;
      write_len_in = write_len_ff;
      scratch_in   = scratch_ff;
      irq_in       = irq_ff;
      result       = '0;

      if (item.opcode == OP_WRITE) begin
         case (item.word_offset)
            OFF_DRAM_ADDR: dram_ptr_in = item.write_data;
            OFF_CART_ADDR: cart_ptr_in = item.write_data;
            OFF_READ_LEN, OFF_WRITE_LEN: begin
               if (item.word_offset == OFF_READ_LEN) begin
                  read_len_in = dma_len;
               end else begin
                  write_len_in = dma_len;
               end
               dram_ptr_in             = {{(32-DRAM_ADDR_W){1'b0}}, dram_start}
                                         + {{(32-LEN_W){1'b0}}, dma_len};
               cart_ptr_in             = cart_start + {{(32-LEN_W){1'b0}}, dma_len};
               irq_in                  = 1'b1;
               result.dma_start        = 1'b1;
               result.dma_to_cart      = (item.word_offset == OFF_READ_LEN);
               result.dma_dram_address = dram_start;
               result.dma_cart_address = cart_start;
               result.dma_length       = dma_len;
            end
            OFF_STATUS: begin
               if (item.write_data[STATUS_IRQ_CLEAR_BIT]) begin
                  irq_in = 1'b0;
               end
            end
            default: begin
               if (is_scratch) begin
                  scratch_in[scratch_idx] = item.write_data[7:0];
               end else begin
                  result.bad_access = 1'b1;
               end
            end
         endcase
      end else begin
         case (item.word_offset)
            OFF_DRAM_ADDR: result.read_data = dram_ptr_ff;
            OFF_CART_ADDR: result.read_data = cart_ptr_ff;
            OFF_READ_LEN:  result.read_data = {{(32-LEN_W){1'b0}}, read_len_ff};
            OFF_WRITE_LEN: result.read_data = {{(32-LEN_W){1'b0}}, write_len_ff};
            OFF_STATUS:    result.read_data[STATUS_IRQ_READ_BIT] = irq_ff;
            default: begin
               if (is_scratch) begin
                  result.read_data = {24'd0, scratch_ff[scratch_idx]};
               end else begin
                  result.bad_access = 1'b1;
               end
            end
         endcase
      end

      result.irq_pending = irq_in;
   end

   // Commit state only when the access moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         dram_ptr_ff  <= '0;
         cart_ptr_ff  <= '0;
         read_len_ff  <= '0;
         write_len_ff <= '0;
         irq_ff       <= 1'b0;
         for (int i = 0; i < SCRATCH_DEPTH; i++) begin
            scratch_ff[i] <= '0;
         end
      end else if (fire) begin
         dram_ptr_ff  <= dram_ptr_in;
         cart_ptr_ff  <= cart_ptr_in;
         read_len_ff  <= read_len_in;
         write_len_ff <= write_len_in;
         irq_ff       <= irq_in;
         scratch_ff   <= scratch_in;
      end
   end

endmodule

// File: rtl/core/cdrb_out_stage.sv
// Result register: holds one finished result until the consumer takes it.
module cdrb_out_stage import cdrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  rsp_type    result,
   output logic       can_accept,
   cdrb_rsp_if.source rsp_bus
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Room when empty or when the held result leaves this cycle
   assign can_accept = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.data  = data_ff;

endmodule

// File: rtl/core/cart_dma_register_block.sv
// Top level of the cart DMA register block: input register, register core, result register.
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+-------------------------------------------
//  req_bus  | in  | valid / ready | opcode, word_offset, write_data
//  rsp_bus  | out | valid / ready | read_data, DMA command, irq, bad_access
//
// One access per cycle sustained while rsp_bus.ready stays high; a request passes through
// the input register, then the result register.
// The register file and the DMA launch math sit combinationally between the two registers.
// Synchronous active-high reset clears both pointers, both lengths, scratch bytes and irq.
// A stalled result holds the result register; the input register still takes one
// more access, after which req_bus.ready drops until the result leaves.
module cart_dma_register_block import cdrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cdrb_req_if.sink   req_bus,
   cdrb_rsp_if.source rsp_bus
);

   logic    held_valid;
   req_type held_item;
   logic    out_can_accept;
   logic    advance;
   rsp_type core_result;

   // Move the held access through the core when the result register has room
   assign advance = held_valid && out_can_accept;

   cdrb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   cdrb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (held_item),
      .result (core_result)
   );

   cdrb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (core_result),
      .can_accept (out_can_accept),
      .rsp_bus    (rsp_bus)
   );

   // DMA fields stay zero unless a launch happened
   a_dma_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.data.dma_start) |->
      (!rsp_bus.data.dma_to_cart && rsp_bus.data.dma_dram_address == '0 &&
       rsp_bus.data.dma_cart_address == '0 && rsp_bus.data.dma_length == '0))
      else $error("DMA fields set without a launch");

   // A launch always leaves the interrupt pending
   a_launch_raises_irq: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.data.dma_start) |-> rsp_bus.data.irq_pending)
      else $error("DMA launch without pending interrupt");

   // A bad offset never launches or returns data
   a_bad_access_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.data.bad_access) |->
      (!rsp_bus.data.dma_start && rsp_bus.data.read_data == '0))
      else $error("Bad access produced side effects");

   // Input stalls only while a finished result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (held_valid && rsp_bus.valid && !rsp_bus.ready))
      else $error("Input stalled without a blocked result");

endmodule
